// ----- design/xlsf_pkg.sv -----
// ----------------------------------------------------------------------------
// xlsf_pkg: shared types and constants for the x86 logic/shift flags unit
// Opcodes, width codes, condition groups and the micro-op passed from the
// decode front end through the queue to the execute back end.
// ----------------------------------------------------------------------------
package xlsf_pkg;

  localparam int DATA_W      = 32;
  localparam int CNT_W       = 5;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = 1;
  localparam int FCNT_W      = 2;

  typedef enum logic [3:0] {
    OP_AND   = 4'd0,
    OP_OR    = 4'd1,
    OP_XOR   = 4'd2,
    OP_TEST  = 4'd3,
    OP_NOT   = 4'd4,
    OP_SAR   = 4'd5,
    OP_SHL   = 4'd6,
    OP_SHR   = 4'd7,
    OP_ROL   = 4'd8,
    OP_SETCC = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    WID_8  = 2'd0,
    WID_16 = 2'd1,
    WID_32 = 2'd2
  } wid_e;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // condition groups, cc[3:1]; cc[0] inverts
  localparam logic [2:0] COND_O  = 3'd0;
  localparam logic [2:0] COND_C  = 3'd1;
  localparam logic [2:0] COND_Z  = 3'd2;
  localparam logic [2:0] COND_BE = 3'd3;
  localparam logic [2:0] COND_S  = 3'd4;
  localparam logic [2:0] COND_P  = 3'd5;
  localparam logic [2:0] COND_L  = 3'd6;
  localparam logic [2:0] COND_LE = 3'd7;

  typedef struct packed {
    logic              illegal;
    op_e               op;
    wid_e              wid;
    logic [DATA_W-1:0] dst;
    logic [DATA_W-1:0] src;
    logic [CNT_W-1:0]  cnt;
    logic [3:0]        cc;
  } uop_t;

  typedef struct packed {
    logic cf;
    logic of;
    logic zf;
    logic sf;
  } flags_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [DATA_W-1:0] width_mask(wid_e wid);
    logic [DATA_W-1:0] m;
    unique case (wid)
      WID_8:   m = 32'h0000_00ff;
      WID_16:  m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic width_msb(logic [DATA_W-1:0] v, wid_e wid);
    logic b;
    unique case (wid)
      WID_8:   b = v[7];
      WID_16:  b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

endpackage

// ----- design/xlsf_front.sv -----
// ----------------------------------------------------------------------------
// xlsf_front: input handshake and instruction decode
// Unpacks the stream item, classifies opcode and operand width, masks the
// destination and extracts the shift count, then pushes a micro-op.
// ----------------------------------------------------------------------------
module xlsf_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [xlsf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  xlsf_pkg::qstat_t                  qstat_i,
  output logic                              push_o,
  output xlsf_pkg::uop_t                    uop_o
);
  import xlsf_pkg::*;

  logic [3:0]        op_raw;
  logic [1:0]        size_raw;
  logic [DATA_W-1:0] dest_raw;
  wid_e              wid;

  assign op_raw   = s_axis_tdata[3:0];
  assign size_raw = s_axis_tdata[5:4];
  assign dest_raw = s_axis_tdata[37:6];

  assign s_axis_tready = !qstat_i.full;
  assign push_o        = s_axis_tvalid && !qstat_i.full;

  always_comb begin
    unique case (size_raw)
      SIZE_BYTE: wid = WID_8;
      SIZE_WORD: wid = WID_16;
      default:   wid = WID_32;  // size code three runs as doubleword
    endcase
  end

  always_comb begin
    uop_o.illegal = (op_raw > OP_SETCC);
    uop_o.op      = uop_o.illegal ? OP_AND : op_e'(op_raw);
    uop_o.wid     = wid;
    uop_o.dst     = dest_raw & width_mask(wid);
    uop_o.src     = s_axis_tdata[69:38];
    uop_o.cnt     = s_axis_tdata[42:38];
    uop_o.cc      = s_axis_tdata[73:70];
  end

endmodule

// ----- design/xlsf_fifo.sv -----
// ----------------------------------------------------------------------------
// xlsf_fifo: two-entry micro-op queue
// Decouples decode from execute; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module xlsf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xlsf_pkg::uop_t   uop_i,
  input  logic             pop_i,
  output xlsf_pkg::uop_t   head_o,
  output xlsf_pkg::qstat_t qstat_o
);
  import xlsf_pkg::*;

  uop_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] count_q, count_d;

  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == FCNT_W'(FIFO_DEPTH));
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + FCNT_W'(push_i) - FCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= uop_i;
    end
  end

endmodule

// ----- design/xlsf_back.sv -----
// ----------------------------------------------------------------------------
// xlsf_back: execute stage with flag state and output register
// Evaluates the queue head against the current flags, updates the flags
// and loads the result register whenever the output slot is free.
// ----------------------------------------------------------------------------
module xlsf_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  xlsf_pkg::uop_t                   head_i,
  input  logic                             head_valid_i,
  output logic                             pop_o,
  output xlsf_pkg::flags_t                 flags_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [xlsf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import xlsf_pkg::*;

  flags_t            flags_q, flags_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] res_q, res_d;
  logic              wb_q, wb_d;
  logic              unsup_q, unsup_d;

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] d;
  logic [DATA_W-1:0] s;
  logic [DATA_W-1:0] sar_ext;
  logic [DATA_W-1:0] logic_r;
  logic [DATA_W-1:0] rol_r;
  logic [15:0]       dbl8;
  logic [31:0]       dbl16;
  logic [63:0]       dbl32;
  logic              cond_v;
  logic              parity_cc;

  assign mask = width_mask(head_i.wid);
  assign d    = head_i.dst;
  assign s    = head_i.src;

  assign pop_o = head_valid_i && (!out_valid_q || m_axis_tready);

  // sign-extend from the operand width, then arithmetic shift
  assign sar_ext = width_msb(d, head_i.wid) ? (d | ~mask) : d;

  // rotate a doubled copy, upper half holds the rotated value
  always_comb begin
    dbl8  = {d[7:0], d[7:0]} << head_i.cnt[2:0];
    dbl16 = {d[15:0], d[15:0]} << head_i.cnt[3:0];
    dbl32 = {d, d} << head_i.cnt;
    unique case (head_i.wid)
      WID_8:   rol_r = {24'b0, dbl8[15:8]};
      WID_16:  rol_r = {16'b0, dbl16[31:16]};
      default: rol_r = dbl32[63:32];
    endcase
  end

  always_comb begin
    unique case (head_i.op)
      OP_OR:   logic_r = (d | s) & mask;
      OP_XOR:  logic_r = (d ^ s) & mask;
      default: logic_r = (d & s) & mask;
    endcase
  end

  always_comb begin
    unique case (head_i.cc[3:1])
      COND_O:  cond_v = flags_q.of;
      COND_C:  cond_v = flags_q.cf;
      COND_Z:  cond_v = flags_q.zf;
      COND_BE: cond_v = flags_q.cf | flags_q.zf;
      COND_S:  cond_v = flags_q.sf;
      COND_L:  cond_v = flags_q.sf ^ flags_q.of;
      COND_LE: cond_v = flags_q.zf | (flags_q.sf ^ flags_q.of);
      default: cond_v = 1'b0;
    endcase
  end

  assign parity_cc = (head_i.cc[3:1] == COND_P);

  always_comb begin
    flags_d = flags_q;
    res_d   = '0;
    wb_d    = 1'b0;
    unsup_d = 1'b0;
    if (!head_i.illegal) begin
      unique case (head_i.op)
        OP_AND, OP_OR, OP_XOR, OP_TEST: begin
          res_d      = logic_r;
          wb_d       = (head_i.op != OP_TEST);
          flags_d.cf = 1'b0;
          flags_d.of = 1'b0;
        end
        OP_NOT: begin
          res_d = ~d & mask;
          wb_d  = 1'b1;
        end
        OP_SAR: begin
          res_d = DATA_W'($signed(sar_ext) >>> head_i.cnt) & mask;
          wb_d  = 1'b1;
        end
        OP_SHL: begin
          res_d = (d << head_i.cnt) & mask;
          wb_d  = 1'b1;
        end
        OP_SHR: begin
          res_d = (d >> head_i.cnt) & mask;
          wb_d  = 1'b1;
        end
        OP_ROL: begin
          res_d = rol_r;
          wb_d  = 1'b1;
          if (head_i.cnt != '0) begin
            flags_d.cf = rol_r[0];
            if (head_i.cnt == CNT_W'(1)) begin
              flags_d.of = width_msb(rol_r, head_i.wid) ^ rol_r[0];
            end
          end
        end
        OP_SETCC: begin
          if (parity_cc) begin
            unsup_d = 1'b1;
          end else begin
            res_d = {31'b0, cond_v ^ head_i.cc[0]};
            wb_d  = 1'b1;
          end
        end
        default: ;
      endcase
      // logic ops and plain shifts take ZF/SF from the result
      if (head_i.op == OP_AND || head_i.op == OP_OR || head_i.op == OP_XOR ||
          head_i.op == OP_TEST || head_i.op == OP_SAR || head_i.op == OP_SHL ||
          head_i.op == OP_SHR) begin
        flags_d.zf = (res_d == '0);
        flags_d.sf = width_msb(res_d, head_i.wid);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        flags_q     <= flags_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q   <= res_d;
      wb_q    <= wb_d;
      unsup_q <= unsup_d;
    end
  end

  assign flags_o       = flags_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b0, unsup_q, flags_q.sf, flags_q.zf, flags_q.of, flags_q.cf,
                          wb_q, res_q};

endmodule

// ----- design/x86_logic_shift_flags_unit.sv -----
// ----------------------------------------------------------------------------
// x86_logic_shift_flags_unit: x86 logic, shift and setcc execution with flags
// Decode front end, two-entry micro-op queue, execute back end holding
// CF/OF/ZF/SF and the result register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one instruction per item (op, size code, destination,
//   source or count, condition code). m_axis returns one item per
//   instruction: the width-truncated result, the write-back bit, the four
//   flags after the instruction and the unsupported mark for parity setcc.
//   An accepted item is written into the queue, then executed from the
//   queue head into the output register that drives m_axis. Throughput:
//   one item per cycle while m_axis_tready stays high, set by the execute
//   stage that reads and updates the flag registers in order.
//   Reset clears the flags to zero and empties the queue and output slot.
//   If m_axis_tready is held low, the output register and the two queue
//   entries fill, after which s_axis_tready drops; no item is dropped.
// ----------------------------------------------------------------------------
module x86_logic_shift_flags_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] op, [5:4] size_code, [37:6] dest_value, [69:38] src_value,
  // [73:70] cond_code, [79:74] zero
  input  logic [xlsf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] result, [32] write_back, [33] carry_flag, [34] overflow_flag,
  // [35] zero_flag, [36] sign_flag, [37] unsupported, [39:38] zero
  output logic [xlsf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import xlsf_pkg::*;

  uop_t   dec_uop;
  uop_t   head_uop;
  qstat_t qstat;
  flags_t flags;
  logic   push;
  logic   pop;

  xlsf_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .qstat_i       (qstat),
    .push_o        (push),
    .uop_o         (dec_uop)
  );

  xlsf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .uop_i   (dec_uop),
    .pop_i   (pop),
    .head_o  (head_uop),
    .qstat_o (qstat)
  );

  xlsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_uop),
    .head_valid_i  (!qstat.empty),
    .pop_o         (pop),
    .flags_o       (flags),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // an accepted item must be queued or already executed next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!qstat.empty || m_axis_tvalid))
    else $error("accepted item vanished");

  // flags change only when an item is executed
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> $stable(flags))
    else $error("flags changed without an executed item");

  // parity setcc neither writes nor returns a value
  a_unsup_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[37]) |-> (!m_axis_tdata[32] && m_axis_tdata[31:0] == '0))
    else $error("unsupported result not quiet");

  // output flag bits track the flag registers
  a_flags_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[36:33] == {flags.sf, flags.zf, flags.of, flags.cf}))
    else $error("output flags differ from flag state");

endmodule

// ----- bench/xlsf_flags_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xlsf_flags_checker: scoreboard for the x86 logic/shift flags unit
// Watches both stream channels. Every accepted instruction is executed
// against a private copy of CF/OF/ZF/SF. Each accepted result item is
// checked field by field against the oldest predicted retirement.
// ----------------------------------------------------------------------------
module xlsf_flags_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [xlsf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [xlsf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                               fail_count_o,
  output int                               outstanding_o
);
  import xlsf_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              wb;
    logic              cf;
    logic              of;
    logic              zf;
    logic              sf;
    logic              unsup;
  } retire_t;

  flags_t  arch_flags;
  retire_t predicted_retires[$];

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    arch_flags    = '0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count_o++;
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic logic cond_holds(logic [3:0] cc);
    logic v;
    case (cc[3:1])
      COND_O:  v = arch_flags.of;
      COND_C:  v = arch_flags.cf;
      COND_Z:  v = arch_flags.zf;
      COND_BE: v = arch_flags.cf | arch_flags.zf;
      COND_S:  v = arch_flags.sf;
      COND_L:  v = arch_flags.sf ^ arch_flags.of;
      COND_LE: v = arch_flags.zf | (arch_flags.sf ^ arch_flags.of);
      default: v = 1'b0;
    endcase
    return v ^ cc[0];
  endfunction

  // executes one instruction, updating arch_flags in program order
  function automatic retire_t execute_instr(logic [3:0] op, logic [1:0] sz,
                                            logic [31:0] dst_raw, logic [31:0] src,
                                            logic [3:0] cc);
    retire_t     res;
    int unsigned w;
    int unsigned k;
    logic [31:0] m;
    logic [31:0] d;
    logic [31:0] r;
    logic [31:0] ext;
    logic [4:0]  cnt;
    res = '0;
    r   = '0;
    case (sz)
      SIZE_BYTE: w = 8;
      SIZE_WORD: w = 16;
      default:   w = 32;  // size code three runs as doubleword
    endcase
    m   = (w == 32) ? 32'hffff_ffff : ((32'd1 << w) - 32'd1);
    d   = dst_raw & m;
    cnt = src[4:0];
    case (op)
      OP_AND, OP_OR, OP_XOR, OP_TEST: begin
        if (op == OP_OR) r = d | src;
        else if (op == OP_XOR) r = d ^ src;
        else r = d & src;
        r &= m;
        res.wb = (op != OP_TEST);
        arch_flags.zf = (r == '0);
        arch_flags.sf = r[w-1];
        arch_flags.cf = 1'b0;
        arch_flags.of = 1'b0;
      end
      OP_NOT: begin
        r = ~d & m;
        res.wb = 1'b1;
      end
      OP_SAR, OP_SHL, OP_SHR: begin
        if (op == OP_SAR) begin
          ext = d[w-1] ? (d | ~m) : d;
          r = 32'($signed(ext) >>> cnt) & m;
        end else if (op == OP_SHL) begin
          r = (d << cnt) & m;
        end else begin
          r = (d >> cnt) & m;
        end
        res.wb = 1'b1;
        arch_flags.zf = (r == '0);
        arch_flags.sf = r[w-1];
      end
      OP_ROL: begin
        k = cnt % w;
        res.wb = 1'b1;
        if (k == 0) r = d;
        else r = ((d << k) | (d >> (w - k))) & m;
        if (cnt != '0) begin
          arch_flags.cf = r[0];
          if (cnt == 5'd1) arch_flags.of = r[w-1] ^ r[0];
        end
      end
      OP_SETCC: begin
        // parity is not tracked: flagged, nothing written
        if (cc[3:1] == COND_P) begin
          res.unsup = 1'b1;
        end else begin
          r = {31'd0, cond_holds(cc)};
          res.wb = 1'b1;
        end
      end
      default: ;
    endcase
    res.value = r;
    res.cf    = arch_flags.cf;
    res.of    = arch_flags.of;
    res.zf    = arch_flags.zf;
    res.sf    = arch_flags.sf;
    return res;
  endfunction

  always @(posedge clk_i) begin
    retire_t want;
    retire_t got;
    if (!rst_ni) begin
      arch_flags = '0;
      predicted_retires.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
               m_axis_tdata[34], m_axis_tdata[35], m_axis_tdata[36],
               m_axis_tdata[37]};
        if (predicted_retires.size() == 0) begin
          report_mismatch("result item with none pending, result", got.value, '0);
        end else begin
          want = predicted_retires.pop_front();
          if (got.value !== want.value) report_mismatch("result", got.value, want.value);
          if (got.wb !== want.wb)
            report_mismatch("write_back", 32'(got.wb), 32'(want.wb));
          if (got.cf !== want.cf)
            report_mismatch("carry_flag", 32'(got.cf), 32'(want.cf));
          if (got.of !== want.of)
            report_mismatch("overflow_flag", 32'(got.of), 32'(want.of));
          if (got.zf !== want.zf)
            report_mismatch("zero_flag", 32'(got.zf), 32'(want.zf));
          if (got.sf !== want.sf)
            report_mismatch("sign_flag", 32'(got.sf), 32'(want.sf));
          if (got.unsup !== want.unsup)
            report_mismatch("unsupported", 32'(got.unsup), 32'(want.unsup));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_retires.push_back(execute_instr(s_axis_tdata[3:0], s_axis_tdata[5:4],
                                                  s_axis_tdata[37:6], s_axis_tdata[69:38],
                                                  s_axis_tdata[73:70]));
      end
    end
    outstanding_o = predicted_retires.size();
  end

endmodule

// ----- bench/x86_logic_shift_flags_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_logic_shift_flags_unit_tb: stimulus and verdict for the flags unit
// Directed instructions first (operand extremes, every opcode, rotate and
// setcc corner cases, unused codes), then random bursts with random gaps
// against a stalling receiver, including long hold-offs that back the unit
// up. Checking lives in xlsf_flags_checker.
// ----------------------------------------------------------------------------
module x86_logic_shift_flags_unit_tb;
  import xlsf_pkg::*;

  localparam int          RANDOM_ITEMS  = 700;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          HOLD_CYCLES   = 60;
  localparam logic [3:0]  OP_UNUSED_LO  = 4'd10;
  localparam logic [3:0]  OP_UNUSED_HI  = 4'd15;
  localparam logic [1:0]  SIZE_UNUSED   = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     fail_count;
  int                     outstanding;
  int                     cycle_count;

  always #5 clk_i = ~clk_i;

  x86_logic_shift_flags_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  xlsf_flags_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // offer one instruction and hold it until the unit takes it
  task automatic push_instr(input logic [3:0] op, input logic [1:0] sz,
                            input logic [31:0] dst, input logic [31:0] src,
                            input logic [3:0] cc);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, cc, src, dst, sz, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom, $urandom});
    end
  endtask

  task automatic push_random_instr();
    logic [3:0]  op;
    logic [1:0]  sz;
    logic [31:0] dst;
    logic [31:0] src;
    op  = ($urandom_range(0, 99) < 92) ? 4'($urandom_range(0, 9))
                                       : 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    sz  = ($urandom_range(0, 15) == 0) ? SIZE_UNUSED : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0:       dst = '0;
      1:       dst = '1;
      2:       dst = 32'd1 << $urandom_range(0, 31);
      default: dst = $urandom;
    endcase
    src = $urandom;
    // keep random upper bits but favor the count edges
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0:       src[4:0] = 5'd0;
        1:       src[4:0] = 5'd1;
        2:       src[4:0] = 5'd31;
        default: src[4:0] = 5'($urandom_range(7, 17));
      endcase
    end
    push_instr(op, sz, dst, src, 4'($urandom_range(0, 15)));
  endtask

  // receiver: stall pattern is redrawn at random from four modes, two long hold-offs
  initial begin
    int rx_cycle;
    int mode;
    int hold_left;
    m_axis_tready = 1'b0;
    rx_cycle      = 0;
    mode          = 0;
    hold_left     = 0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle == 150 || rx_cycle == 900) hold_left = HOLD_CYCLES;
      if (rx_cycle % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (rx_cycle % 8) < 5;
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("x86_logic_shift_flags_unit: mismatch");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    int gap;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // logic ops at the operand extremes
    push_instr(OP_AND,  WID_32, 32'hffff_ffff, 32'hffff_ffff, 4'd0);
    push_instr(OP_OR,   WID_8,  32'h0000_0000, 32'h0000_0000, 4'd0);
    push_instr(OP_XOR,  WID_16, 32'hffff_ffff, 32'h0000_8000, 4'd0);
    push_instr(OP_TEST, WID_32, 32'hffff_ffff, 32'h8000_0000, 4'd0);
    push_instr(OP_NOT,  WID_8,  32'hffff_ff00, 32'h0000_0000, 4'd0);
    // sar sign at each width, zero count with junk upper count bits
    push_instr(OP_SAR,  WID_8,  32'h0000_0080, 32'h0000_0007, 4'd0);
    push_instr(OP_SAR,  WID_16, 32'h0000_8001, 32'hffff_ffe0, 4'd0);
    push_instr(OP_SAR,  WID_32, 32'h8000_0000, 32'h0000_001f, 4'd0);
    push_instr(OP_SHL,  WID_16, 32'h0000_ffff, 32'h0000_000f, 4'd0);
    push_instr(OP_SHR,  SIZE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 4'd0);
    // rotate: count one, zero, past width, max, multiple of width
    push_instr(OP_ROL,  WID_8,  32'h0000_0081, 32'h0000_0001, 4'd0);
    push_instr(OP_ROL,  WID_16, 32'h0000_8000, 32'h0000_0000, 4'd0);
    push_instr(OP_ROL,  WID_8,  32'h0000_005a, 32'h0000_0009, 4'd0);
    push_instr(OP_ROL,  WID_32, 32'h8000_0001, 32'h0000_001f, 4'd0);
    push_instr(OP_ROL,  WID_8,  32'h0000_0001, 32'h0000_0008, 4'd0);
    // one setcc per condition group, both parity codes
    for (int g = 0; g < 8; g++) begin
      push_instr(OP_SETCC, WID_8, 32'd0, 32'd0, {3'(g), 1'(g % 2)});
    end
    push_instr(OP_SETCC, WID_32, 32'd0, 32'd0, {COND_P, 1'b0});
    push_instr(OP_UNUSED_HI, WID_32, 32'hffff_ffff, 32'hffff_ffff, 4'hf);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        push_random_instr();
        burst--;
        sent++;
      end
      if (gap > 0) idle_sender(gap);
    end
    idle_sender(1);

    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("x86_logic_shift_flags_unit: match");
    end else begin
      $display("x86_logic_shift_flags_unit: mismatch");
    end
    $finish;
  end

endmodule
